/* hw/rtl/sine_lfo_flanger_top_macros.svh */
// ----------------------------------------------------------------------------
// sine_lfo_flanger_top_macros.svh
// Assertion macros used by the flanger checker.
// ----------------------------------------------------------------------------
`ifndef SINE_LFO_FLANGER_TOP_MACROS_SVH
`define SINE_LFO_FLANGER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slf_pkg.sv */
// ----------------------------------------------------------------------------
// slf_pkg
// Shared constants, types and the sine table builder of the flanger.
// ----------------------------------------------------------------------------
`default_nettype none

package slf_pkg;

  localparam int MAX_DELAY_SAMPLES = 4096;
  localparam int SINE_TABLE_SIZE   = 1024;
  localparam int FRAC_BITS         = 8;

  localparam int SAMPLE_W   = 16;
  localparam int BUF_LEN_W  = 13;
  localparam int BASE_W     = 20;
  localparam int DEPTH_W    = 20;
  localparam int PHASE_W    = 16;
  localparam int SINE_W     = 16;
  localparam int SINE_FRAC  = 15;

  localparam int ADDR_W     = $clog2(MAX_DELAY_SAMPLES);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_SIZE);

  localparam int PROD_W     = DEPTH_W + SINE_W + 1;
  localparam int OFFSET_W   = PROD_W - SINE_FRAC;
  localparam int DELAY_W    = OFFSET_W + 1;
  localparam int POS_W      = ((ADDR_W + FRAC_BITS > DELAY_W) ?
                               ADDR_W + FRAC_BITS : DELAY_W) + 2;
  localparam int P_W        = POS_W - FRAC_BITS;
  localparam int DIV_STEPS  = (P_W + 1) / 2;
  localparam int DIV_W      = 2 * DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int MIX_W      = SAMPLE_W + FRAC_BITS + 2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int REG_COUNT  = 4;
  localparam int PADDR_W    = $clog2(4 * REG_COUNT);
  localparam int PDATA_W    = 32;

  localparam logic [BUF_LEN_W-1:0] BUF_LEN_RST = BUF_LEN_W'(4096);
  localparam logic [BASE_W-1:0]    BASE_RST    = BASE_W'(65536);

  typedef enum logic [1:0] {
    REG_BUFFER_LENGTH = 2'd0,
    REG_BASE_DELAY    = 2'd1,
    REG_MOD_DEPTH     = 2'd2,
    REG_PHASE_STEP    = 2'd3
  } slf_reg_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_delay;
    logic [DEPTH_W-1:0] mod_depth;
    logic [PHASE_W-1:0] phase_step;
  } slf_lfo_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry_sample;
    logic                       block_end;
    logic signed [DELAY_W-1:0]  delay;
  } slf_item_t;

  typedef logic signed [SINE_W-1:0] slf_sine_rom_t [SINE_TABLE_SIZE];

  // polynomial quarter-wave sine, angle in 16-bit turn units, q1.15 result
  function automatic logic signed [SINE_W-1:0] sine_of_turn(input logic [15:0] a);
    int unsigned z;
    int unsigned z2;
    int unsigned t;
    int unsigned y;
    logic [1:0] quad;
    logic signed [SINE_W-1:0] ys;
    quad = a[15:14];
    z    = int'(a[13:0]);
    if (quad[0]) begin
      z = 16384 - z;
    end
    z2 = (z * z) >> 14;
    t  = (2320 * z2) >> 14;
    t  = 21024 - t;
    t  = (t * z2) >> 14;
    t  = 51472 - t;
    y  = (t * z) >> 14;
    if (y > 32767) begin
      y = 32767;
    end
    ys = SINE_W'(y);
    return quad[1] ? -ys : ys;
  endfunction

  function automatic slf_sine_rom_t build_sine_rom();
    slf_sine_rom_t rom;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      rom[i] = sine_of_turn(16'((i * 65536) / SINE_TABLE_SIZE));
    end
    return rom;
  endfunction

  function automatic logic [LEN_W-1:0] effective_length(input logic [BUF_LEN_W-1:0] bl);
    logic [LEN_W-1:0] len;
    if (bl == '0) begin
      len = LEN_W'(1);
    end else if (32'(bl) > 32'(MAX_DELAY_SAMPLES)) begin
      len = LEN_W'(MAX_DELAY_SAMPLES);
    end else begin
      len = LEN_W'(bl);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/slf_front.sv */
// ----------------------------------------------------------------------------
// slf_front
// Input side: takes samples, steps the lfo and works out each sample's delay.
// ----------------------------------------------------------------------------
`default_nettype none

module slf_front import slf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  slf_lfo_cfg_t               lfo_cfg,
  input  logic                       clear_done,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] dry_sample,
  input  logic                       block_end,
  output logic                       push,
  output slf_item_t                  push_item,
  input  logic                       full
);

  localparam slf_sine_rom_t SINE_ROM = build_sine_rom();

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } state_t;

  state_t                     state;
  logic [PHASE_W-1:0]         lfo_phase;
  logic signed [SAMPLE_W-1:0] dry_q;
  logic                       block_end_q;
  logic signed [SINE_W-1:0]   sine_q;
  logic signed [PROD_W-1:0]   prod_q;

  assign in_ready = (state == F_IDLE) && clear_done;
  assign push     = (state == F_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      lfo_phase <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            dry_q       <= dry_sample;
            block_end_q <= block_end;
            sine_q      <= SINE_ROM[lfo_phase[PHASE_W-1 -: SINE_IDX_W]];
            lfo_phase   <= lfo_phase + lfo_cfg.phase_step;
            state       <= F_MUL;
          end
        end
        F_MUL: begin
          prod_q <= $signed({1'b0, lfo_cfg.mod_depth}) * sine_q;
          state  <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // arithmetic shift gives the floor of the scaled swing
  always_comb begin
    push_item.dry_sample = dry_q;
    push_item.block_end  = block_end_q;
    push_item.delay      = $signed({{(DELAY_W-BASE_W){1'b0}}, lfo_cfg.base_delay})
                         + $signed({{(DELAY_W-OFFSET_W){prod_q[PROD_W-1]}},
                                    prod_q[PROD_W-1:SINE_FRAC]});
  end

endmodule

`default_nettype wire

/* hw/rtl/slf_fifo.sv */
// ----------------------------------------------------------------------------
// slf_fifo
// Short queue of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module slf_fifo import slf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  slf_item_t push_item,
  output logic      full,
  input  logic      pop,
  output slf_item_t pop_item,
  output logic      empty
);

  slf_item_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;

  assign full     = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/slf_back.sv */
// ----------------------------------------------------------------------------
// slf_back
// Execution side: wraps the read position, reads the delay line,
// interpolates, mixes and writes the dry sample back.
// ----------------------------------------------------------------------------
`default_nettype none

module slf_back import slf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [BUF_LEN_W-1:0]        buffer_length,
  input  logic                        empty,
  input  slf_item_t                   pop_item,
  output logic                        pop,
  output logic                        clear_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  wet_sample,
  output logic                        block_end_out
);

  localparam logic signed [MIX_W-1:0] ROUND_BIAS = MIX_W'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [MIX_W-1:0] SAMPLE_MAX = MIX_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [MIX_W-1:0] SAMPLE_MIN = -MIX_W'(1 << (SAMPLE_W - 1));

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DIV,
    B_FIX,
    B_RD1,
    B_RD2,
    B_MIX
  } state_t;

  state_t                     state;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          wp;
  logic [LEN_W-1:0]           rem;
  logic [DIV_W-1:0]           mag;
  logic [DIV_CNT_W-1:0]       step_cnt;
  logic                       neg;
  logic [FRAC_BITS-1:0]       frac;
  logic [ADDR_W-1:0]          i1;
  logic [ADDR_W-1:0]          i2;
  logic signed [SAMPLE_W-1:0] dry_q;
  logic                       block_end_q;
  logic signed [SAMPLE_W-1:0] x1;
  logic signed [SAMPLE_W-1:0] rd_data;

  logic signed [SAMPLE_W-1:0] mem [MAX_DELAY_SAMPLES];

  logic [LEN_W-1:0]           len;
  logic [ADDR_W-1:0]          wp_eff;
  logic signed [POS_W-1:0]    pos;
  logic [P_W-1:0]             p_bits;
  logic [P_W-1:0]             p_abs;
  logic [LEN_W:0]             r0;
  logic [LEN_W-1:0]           r1;
  logic [LEN_W:0]             r2;
  logic [LEN_W-1:0]           rem_next;
  logic [LEN_W-1:0]           i1p;
  logic [LEN_W-1:0]           wp_inc;
  logic                       out_free;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          rd_addr;
  logic [FRAC_BITS:0]         w1;
  logic signed [MIX_W-1:0]    total;
  logic signed [MIX_W-1:0]    total_adj;
  logic signed [MIX_W-1:0]    mix_full;
  logic signed [SAMPLE_W-1:0] mix;

  assign len        = effective_length(buffer_length);
  assign clear_done = (state != B_CLEAR);
  assign pop        = (state == B_IDLE) && !empty;
  assign out_free   = !out_valid || out_ready;

  // read position in q.frac samples; floor part wraps modulo len
  always_comb begin
    wp_eff = ({1'b0, wp} >= len) ? '0 : wp;
    pos    = $signed({{(POS_W-ADDR_W-FRAC_BITS){1'b0}}, wp_eff, {FRAC_BITS{1'b0}}})
           - $signed({{(POS_W-DELAY_W){pop_item.delay[DELAY_W-1]}}, pop_item.delay});
    p_bits = pos[POS_W-1:FRAC_BITS];
    p_abs  = pos[POS_W-1] ? (~p_bits + 1'b1) : p_bits;
  end

  // two restoring remainder steps per cycle
  always_comb begin
    r0       = {rem, mag[DIV_W-1]};
    r1       = (r0 >= {1'b0, len}) ? LEN_W'(r0 - {1'b0, len}) : LEN_W'(r0);
    r2       = {r1, mag[DIV_W-2]};
    rem_next = (r2 >= {1'b0, len}) ? LEN_W'(r2 - {1'b0, len}) : LEN_W'(r2);
  end

  always_comb begin
    i1p    = {1'b0, i1} + 1'b1;
    wp_inc = {1'b0, wp} + 1'b1;
  end

  // linear blend, then halve with truncation toward zero
  always_comb begin
    w1        = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    total     = $signed({{(MIX_W-SAMPLE_W-FRAC_BITS){dry_q[SAMPLE_W-1]}}, dry_q,
                         {FRAC_BITS{1'b0}}})
              + x1 * $signed({1'b0, w1})
              + rd_data * $signed({1'b0, frac});
    total_adj = total[MIX_W-1] ? total + ROUND_BIAS : total;
    mix_full  = total_adj >>> (FRAC_BITS + 1);
    if (mix_full > SAMPLE_MAX) begin
      mix = SAMPLE_W'(SAMPLE_MAX);
    end else if (mix_full < SAMPLE_MIN) begin
      mix = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      mix = SAMPLE_W'(mix_full);
    end
  end

  // second tap stays on the read port while the mix waits for the output
  always_comb begin
    mem_we    = (state == B_CLEAR) || ((state == B_MIX) && out_free);
    mem_waddr = (state == B_CLEAR) ? clr_addr : wp;
    mem_wdata = (state == B_CLEAR) ? '0 : dry_q;
    rd_addr   = ((state == B_RD2) || (state == B_MIX)) ? i2 : i1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == B_MIX) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAX_DELAY_SAMPLES - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            dry_q       <= pop_item.dry_sample;
            block_end_q <= pop_item.block_end;
            neg         <= pos[POS_W-1];
            frac        <= pos[FRAC_BITS-1:0];
            mag         <= DIV_W'(p_abs);
            rem         <= '0;
            step_cnt    <= '0;
            wp          <= wp_eff;
            state       <= B_DIV;
          end
        end
        B_DIV: begin
          rem      <= rem_next;
          mag      <= mag << 2;
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= B_FIX;
          end
        end
        B_FIX: begin
          // negative position folds back from the top of the buffer
          i1    <= (neg && (rem != '0)) ? ADDR_W'(len - rem) : ADDR_W'(rem);
          state <= B_RD1;
        end
        B_RD1: begin
          i2    <= (i1p >= len) ? '0 : ADDR_W'(i1p);
          state <= B_RD2;
        end
        B_RD2: begin
          x1    <= rd_data;
          state <= B_MIX;
        end
        B_MIX: begin
          if (out_free) begin
            wet_sample    <= mix;
            block_end_out <= block_end_q;
            wp            <= (wp_inc >= len) ? '0 : ADDR_W'(wp_inc);
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sine_lfo_flanger_top.sv */
// ----------------------------------------------------------------------------
// sine_lfo_flanger_top
// Sine-lfo flanger with a linearly interpolated delay line.
// ----------------------------------------------------------------------------
// Samples enter on in_valid/in_ready (dry_sample, block_end) and leave on
// out_valid/out_ready (wet_sample, block_end_out), one result per sample,
// in order. Settings are written over the apb port: buffer_length at 0x0,
// base_delay at 0x4, mod_depth at 0x8, phase_step at 0xc; write them only
// while no sample is in flight.
// The front end takes a sample when idle and computes its delay from
// the lfo; a two-entry queue feeds the back end, which runs each sample
// through the remainder unit that wraps the read position (two bits per
// cycle), then through two reads of the delay-line read port and the mix.
// The front end can take new samples while the back end is still busy,
// until the queue is full.
// After reset every entry of the delay line is cleared with in_ready low;
// configuration writes are taken during that time.
// A stalled receiver holds the result in the output register; the back end
// waits, the queue fills and in_ready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_lfo_flanger_top import slf_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  dry_sample,
  input  logic                        block_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  wet_sample,
  output logic                        block_end_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  logic [BUF_LEN_W-1:0] buffer_length;
  slf_lfo_cfg_t         lfo_cfg;
  slf_reg_t             reg_sel;
  logic                 cfg_we;

  logic                 clear_done;
  logic                 push;
  slf_item_t            push_item;
  logic                 full;
  logic                 pop;
  slf_item_t            pop_item;
  logic                 empty;

  assign pready  = 1'b1;
  assign reg_sel = slf_reg_t'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length      <= BUF_LEN_RST;
      lfo_cfg.base_delay <= BASE_RST;
      lfo_cfg.mod_depth  <= '0;
      lfo_cfg.phase_step <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_BUFFER_LENGTH: buffer_length      <= pwdata[BUF_LEN_W-1:0];
        REG_BASE_DELAY:    lfo_cfg.base_delay <= pwdata[BASE_W-1:0];
        REG_MOD_DEPTH:     lfo_cfg.mod_depth  <= pwdata[DEPTH_W-1:0];
        REG_PHASE_STEP:    lfo_cfg.phase_step <= pwdata[PHASE_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BUFFER_LENGTH: prdata = PDATA_W'(buffer_length);
      REG_BASE_DELAY:    prdata = PDATA_W'(lfo_cfg.base_delay);
      REG_MOD_DEPTH:     prdata = PDATA_W'(lfo_cfg.mod_depth);
      REG_PHASE_STEP:    prdata = PDATA_W'(lfo_cfg.phase_step);
      default:           prdata = '0;
    endcase
  end

  slf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .lfo_cfg    (lfo_cfg),
    .clear_done (clear_done),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dry_sample (dry_sample),
    .block_end  (block_end),
    .push       (push),
    .push_item  (push_item),
    .full       (full)
  );

  slf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  slf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .buffer_length (buffer_length),
    .empty         (empty),
    .pop_item      (pop_item),
    .pop           (pop),
    .clear_done    (clear_done),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wet_sample    (wet_sample),
    .block_end_out (block_end_out)
  );

endmodule

`default_nettype wire

/* hw/rtl/slf_checker.sv */
// ----------------------------------------------------------------------------
// slf_checker
// Port-level checks of the flanger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sine_lfo_flanger_top_macros.svh"

module slf_checker import slf_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [SAMPLE_W-1:0]  wet_sample,
  input logic                        block_end_out
);

  // a stalled result stays put
  `SLF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(wet_sample) && $stable(block_end_out), "output changed while stalled")

  // the delay-line clearing pass blocks input right after reset
  `SLF_ASSERT_NOW(a_clear_after_reset, clk, rst, $fell(rst), !in_ready, "input taken during clearing pass")

  // the front end is busy with the lfo product after each transaction
  `SLF_ASSERT_NEXT(a_front_busy, clk, rst, in_valid && in_ready, !in_ready, "front end took samples back to back")

endmodule

bind sine_lfo_flanger_top slf_checker u_slf_checker (.*);

`default_nettype wire

/* test/tb_sine_lfo_flanger_top.sv */
// ----------------------------------------------------------------------------
// tb_sine_lfo_flanger_top
// Self-checking bench for the sine-lfo flanger.
// ----------------------------------------------------------------------------
// Streams audio samples through the valid/ready input and programs the
// delay-line length, centre delay, swing depth and lfo step over apb between
// phases. Every wet sample is predicted by an untimed model of the lfo, the
// interpolating delay line and the mixer, and compared in order. Phases vary
// the settings, extremes included, and the idle pattern on both sides; one
// phase holds the output off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_sine_lfo_flanger_top;
  import slf_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int RAND_ITEMS    = 650;
  localparam int RAND_PHASES   = 12;
  localparam int IDLE_PCT      = 52;
  localparam int IDLE_BOTH_PCT = 11;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_PRINTS    = 50;
  localparam int RUN_LIMIT     = 2000000;
  localparam int BUF_LEN_MAX   = (1 << BUF_LEN_W) - 1;
  localparam int ONE_SAMPLE    = 1 << FRAC_BITS;

  typedef struct {
    logic signed [SAMPLE_W-1:0] dry;
    logic                       last;
  } sample_txn_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] wet;
    logic                       last;
  } wet_txn_t;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] dry_sample = '0;
  logic                       block_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] wet_sample;
  logic                       block_end_out;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  sine_lfo_flanger_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .dry_sample    (dry_sample),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wet_sample    (wet_sample),
    .block_end_out (block_end_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // flanger model state
  logic signed [SAMPLE_W-1:0] dl_mem [MAX_DELAY_SAMPLES];
  int                         sine_lut [SINE_TABLE_SIZE];
  int                         wr_idx;
  logic [PHASE_W-1:0]         lfo_acc;
  logic [BUF_LEN_W-1:0]       cfg_len;
  logic [BASE_W-1:0]          cfg_base;
  logic [DEPTH_W-1:0]         cfg_depth;
  logic [PHASE_W-1:0]         cfg_step;

  sample_txn_t pending_q[$];
  wet_txn_t    wet_expect_q[$];
  int          n_pushed = 0;
  int          n_accepted = 0;
  int          n_errors = 0;
  bit          in_fire = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_req = 0;
  int          rx_hold_left = 0;

  // q1.15 quarter-wave polynomial sine, one entry per 1/1024 turn
  initial begin
    longint     z;
    longint     z2;
    longint     t;
    longint     y;
    logic [15:0] ang;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      ang = 16'((k * 65536) / SINE_TABLE_SIZE);
      z = longint'(ang[13:0]);
      if (ang[14]) begin
        z = 16384 - z;
      end
      z2 = (z * z) >> 14;
      t  = 21024 - ((2320 * z2) >> 14);
      t  = 51472 - ((t * z2) >> 14);
      y  = (t * z) >> 14;
      if (y > 32767) begin
        y = 32767;
      end
      sine_lut[k] = ang[15] ? -int'(y) : int'(y);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] predict_wet(
    input logic signed [SAMPLE_W-1:0] dry
  );
    longint len;
    longint modulus;
    longint delay;
    longint pos;
    longint total;
    longint mix;
    int     tap0;
    int     tap1;
    int     frac;
    if (cfg_len == 0) begin
      len = 1;
    end else if (cfg_len > MAX_DELAY_SAMPLES) begin
      len = MAX_DELAY_SAMPLES;
    end else begin
      len = longint'(cfg_len);
    end
    if (wr_idx >= len) begin
      wr_idx = 0;
    end
    // depth * sine floored to q.8 samples, never clamped
    delay = longint'(cfg_base) +
            ((longint'(cfg_depth) * sine_lut[lfo_acc >> (PHASE_W - SINE_IDX_W)]) >>> 15);
    modulus = len << FRAC_BITS;
    pos = (longint'(wr_idx) << FRAC_BITS) - delay;
    pos = pos % modulus;
    if (pos < 0) begin
      pos = pos + modulus;
    end
    tap0 = int'(pos >> FRAC_BITS);
    frac = int'(pos & (ONE_SAMPLE - 1));
    tap1 = (tap0 + 1 >= len) ? 0 : tap0 + 1;
    total = (longint'(dry) <<< FRAC_BITS)
          + longint'(dl_mem[tap0]) * (ONE_SAMPLE - frac)
          + longint'(dl_mem[tap1]) * frac;
    mix = total / (2 * ONE_SAMPLE);
    if (mix > 32767) begin
      mix = 32767;
    end else if (mix < -32768) begin
      mix = -32768;
    end
    // read happens before the dry sample goes into the line
    dl_mem[wr_idx] = dry;
    wr_idx = (wr_idx + 1 >= len) ? 0 : wr_idx + 1;
    lfo_acc = lfo_acc + cfg_step;
    return SAMPLE_W'(mix);
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (n_errors < MAX_PRINTS) begin
      $display("error: %s: got %0d, expected %0d (t=%0t)", what, got_v, want_v, $time);
    end
    n_errors++;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] d, input logic last);
    sample_txn_t s;
    s.dry  = d;
    s.last = last;
    pending_q.push_back(s);
    n_pushed++;
  endtask

  // audio blocks of random size, the last sample of each marked
  task automatic push_blocks(input int n);
    int blen;
    int left;
    logic signed [SAMPLE_W-1:0] d;
    left = n;
    while (left > 0) begin
      blen = $urandom_range(1, 24);
      if (blen > left) begin
        blen = left;
      end
      for (int k = 0; k < blen; k++) begin
        case ($urandom_range(0, 15))
          0: begin
            d = 16'sh7fff;
          end
          1: begin
            d = 16'sh8000;
          end
          default: begin
            d = SAMPLE_W'($urandom);
          end
        endcase
        push_sample(d, k == blen - 1);
      end
      left = left - blen;
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || wet_expect_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      IDLE_TX: begin
        tx_idle_pct  = IDLE_PCT;
        rx_stall_pct = 0;
      end
      IDLE_RX: begin
        tx_idle_pct  = 0;
        rx_stall_pct = IDLE_PCT;
      end
      default: begin
        tx_idle_pct  = IDLE_BOTH_PCT;
        rx_stall_pct = IDLE_BOTH_PCT;
      end
    endcase
  endtask

  task automatic apb_write(input slf_reg_t r, input logic [PDATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(r) * 4);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    case (r)
      REG_BUFFER_LENGTH: begin
        cfg_len = v[BUF_LEN_W-1:0];
      end
      REG_BASE_DELAY: begin
        cfg_base = v[BASE_W-1:0];
      end
      REG_MOD_DEPTH: begin
        cfg_depth = v[DEPTH_W-1:0];
      end
      REG_PHASE_STEP: begin
        cfg_step = v[PHASE_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_lfo(input logic [PDATA_W-1:0] len_w, input logic [PDATA_W-1:0] base_w,
                             input logic [PDATA_W-1:0] depth_w,
                             input logic [PDATA_W-1:0] step_w);
    apb_write(REG_BUFFER_LENGTH, len_w);
    apb_write(REG_BASE_DELAY, base_w);
    apb_write(REG_MOD_DEPTH, depth_w);
    apb_write(REG_PHASE_STEP, step_w);
  endtask

  // input driver
  always @(negedge clk) begin
    sample_txn_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        cur = pending_q.pop_front();
        in_valid   <= 1'b1;
        dry_sample <= cur.dry;
        block_end  <= cur.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output ready, with an occasional long hold-off
  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // predict on input transactions, check output transactions
  always @(posedge clk) begin
    wet_txn_t want;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      want.wet  = predict_wet(dry_sample);
      want.last = block_end;
      wet_expect_q.push_back(want);
      n_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      if (wet_expect_q.size() == 0) begin
        report_mismatch("output transaction with nothing expected", int'(wet_sample), 0);
      end else begin
        want = wet_expect_q.pop_front();
        if (wet_sample !== want.wet) begin
          report_mismatch("wet_sample", int'(wet_sample), int'(want.wet));
        end
        if (block_end_out !== want.last) begin
          report_mismatch("block_end_out", int'(block_end_out), int'(want.last));
        end
      end
    end
  end

  initial begin
    int len_v;
    int eff;
    int base_v;
    int depth_v;
    int n;
    logic [PDATA_W-1:0] len_w;
    logic [PDATA_W-1:0] base_w;
    logic [PDATA_W-1:0] depth_w;
    logic [PDATA_W-1:0] step_w;

    for (int k = 0; k < MAX_DELAY_SAMPLES; k++) begin
      dl_mem[k] = '0;
    end
    wr_idx    = 0;
    lfo_acc   = '0;
    cfg_len   = BUF_LEN_RST;
    cfg_base  = BASE_RST;
    cfg_depth = '0;
    cfg_step  = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // reset settings, field extremes
    set_idle(IDLE_NONE);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shffff, 1'b1);
    push_sample(16'sh0001, 1'b0);
    push_sample(16'sh5555, 1'b0);
    wait_drained();

    // zero length acts as one, and the write pointer is left beyond it
    program_lfo(0, 0, 0, 0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    wait_drained();

    // oversized length, full swing reads ahead of the write pointer
    program_lfo(BUF_LEN_MAX, 32'h80, 32'hfffff, 32'hffff);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'shaaaa, 1'b1);
    wait_drained();

    // just above the maximum length, largest centre delay
    program_lfo(MAX_DELAY_SAMPLES + 1, 32'hfffff, 0, 32'h4000);
    push_sample(16'sh1234, 1'b0);
    push_sample(16'shedcb, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    wait_drained();

    // two-sample line, fractional delay with a small swing
    program_lfo(2, 32'h180, 32'h100, 32'h4000);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh4000, 1'b0);
    push_sample(16'shc000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0: begin
          len_v = 0;
        end
        1: begin
          len_v = $urandom_range(MAX_DELAY_SAMPLES + 1, BUF_LEN_MAX);
        end
        2: begin
          len_v = MAX_DELAY_SAMPLES;
        end
        3, 4, 5, 6: begin
          len_v = $urandom_range(1, 32);
        end
        default: begin
          len_v = $urandom_range(1, MAX_DELAY_SAMPLES);
        end
      endcase
      eff = (len_v == 0) ? 1 : ((len_v > MAX_DELAY_SAMPLES) ? MAX_DELAY_SAMPLES : len_v);
      case ($urandom_range(0, 7))
        0: begin
          base_v = 0;
        end
        1: begin
          base_v = (1 << BASE_W) - 1;
        end
        2, 3, 4, 5: begin
          base_v = $urandom_range(0, eff << (FRAC_BITS + 1));
        end
        default: begin
          base_v = $urandom_range(0, (1 << BASE_W) - 1);
        end
      endcase
      case ($urandom_range(0, 7))
        0: begin
          depth_v = 0;
        end
        1: begin
          depth_v = (1 << DEPTH_W) - 1;
        end
        2, 3, 4, 5: begin
          depth_v = $urandom_range(0, eff << FRAC_BITS);
        end
        default: begin
          depth_v = $urandom_range(0, (1 << DEPTH_W) - 1);
        end
      endcase
      // unused upper bits of each word carry noise
      len_w   = $urandom;
      base_w  = $urandom;
      depth_w = $urandom;
      step_w  = $urandom;
      len_w[BUF_LEN_W-1:0] = BUF_LEN_W'(len_v);
      base_w[BASE_W-1:0]   = BASE_W'(base_v);
      depth_w[DEPTH_W-1:0] = DEPTH_W'(depth_v);
      case ($urandom_range(0, 5))
        0: begin
          step_w[PHASE_W-1:0] = '0;
        end
        1: begin
          step_w[PHASE_W-1:0] = '1;
        end
        default: begin
        end
      endcase
      program_lfo(len_w, base_w, depth_w, step_w);
      set_idle(idle_mode_t'(p % 4));
      n = RAND_ITEMS / RAND_PHASES;
      if (p == 5) begin
        // back the block up: output held while the input keeps offering
        push_blocks(n);
        @(posedge clk);
        rx_hold_req = HOLD_CYCLES;
      end else if (p == 6) begin
        // sender pauses until the block is empty
        push_blocks(n / 2);
        wait_drained();
        push_blocks(n - n / 2);
      end else begin
        push_blocks(n);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wet_expect_q.size() != 0) begin
      report_mismatch("results never delivered", wet_expect_q.size(), 0);
    end
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d results outstanding", wet_expect_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
